@@ sv/bpu_pkg.sv @@
package bpu_pkg;

    // Geometry limits and storage sizes
    localparam logic [12:0] MAX_DIM    = 13'd4096;
    localparam int          PAL_DEPTH  = 256;
    localparam int          PAL_AW     = 8;
    localparam int          COLOUR_W   = 32;
    localparam int          FIFO_DEPTH = 4;
    localparam int          FIFO_AW    = 2;
    localparam int          CNT_W      = 3;

    // Stream and register port widths
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 56;
    localparam int APB_AW     = 4;

    // Register indexes (byte address / 4)
    localparam logic [1:0] REG_DEPTH  = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    // Input kinds carried on tuser
    localparam logic KIND_PALETTE = 1'b0;
    localparam logic KIND_PIXEL   = 1'b1;

    typedef enum logic [2:0] {
        DM_1BPP  = 3'd0,
        DM_4BPP  = 3'd1,
        DM_8BPP  = 3'd2,
        DM_24BPP = 3'd3,
        DM_32BPP = 3'd4
    } t_depth;

    // Pixels of one byte (or one assembled 24/32 bpp colour) waiting to issue
    typedef struct packed {
        logic [11:0]         x;
        logic [11:0]         y;
        logic [3:0]          rem;
        logic [7:0]          sh;
        logic [COLOUR_W-1:0] colour;
        t_depth              depth;
        logic                row0;
    } t_job;

    typedef struct packed {
        logic [11:0]         x;
        logic [11:0]         y;
        logic [COLOUR_W-1:0] colour;
        logic                run_last;
        logic                frame_last;
    } t_pix;

    // Clamp a width or height register to 1..MAX_DIM
    function automatic logic [12:0] eff_dim(input logic [12:0] v);
        logic [12:0] r;
        if (v == 13'd0) begin
            r = 13'd1;
        end else if (v > MAX_DIM) begin
            r = MAX_DIM;
        end else begin
            r = v;
        end
        return r;
    endfunction

    function automatic t_depth eff_depth(input logic [2:0] v);
        t_depth r;
        unique case (v)
            3'd0:    r = DM_1BPP;
            3'd1:    r = DM_4BPP;
            3'd2:    r = DM_8BPP;
            3'd3:    r = DM_24BPP;
            default: r = DM_32BPP;
        endcase
        return r;
    endfunction

endpackage

@@ sv/bpu_ram.sv @@
module bpu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Read returns the old contents on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

@@ sv/bmp_pixel_unpacker.sv @@
// BMP pixel array unpacker. Feed the pixel array of a BMP image as bytes
// (tuser high) and load palette entries (tuser low) on the slave stream; the
// master stream gives one transfer per pixel with column, row counted from
// the top, and 32-bit colour. Depths of 1, 4 and 8 bpp look the colour up in
// a 256-entry palette that must be loaded before it is used; 24 bpp gives
// 0x00RRGGBB and 32 bpp the four bytes little-endian. Rows arrive bottom-up,
// each padded to a multiple of four bytes; padding bytes and packed pixels
// beyond the image width give no pixels. Any register write restarts the
// frame at the bottom row and keeps the palette; write registers only while
// the block is idle. Palette loads and 8, 24 and 32 bpp bytes are taken one
// per cycle while the result slots have room; a 1 or 4 bpp byte gives its
// pixels (up to 8 or 2) one per cycle, as the palette memory has a single
// read port. A pixel goes from its byte via the job register, the palette
// read stage and a result slot to the master side. tuser there marks the
// last pixel of a byte, tlast the final pixel; four slots decouple sides.
module bmp_pixel_unpacker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // slave stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // palette_index [7:0], palette_value [39:8], data_byte [47:40]
    input  logic [bpu_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // mode
    input  logic                            s_axis_tuser,
    // master stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // pixel_x [11:0], pixel_y [23:12], colour [55:24]
    output logic [bpu_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // frame_last
    output logic                            m_axis_tlast,
    // run_last
    output logic                            m_axis_tuser,
    // register port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [bpu_pkg::APB_AW-1:0]      paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    import bpu_pkg::*;

    // Registers
    logic [2:0]  r_depth;
    logic [12:0] r_width;
    logic [12:0] r_height;

    // Frame position
    logic [11:0] r_row, n_row;
    logic [12:0] r_col, n_col;
    logic [14:0] r_rbc, n_rbc;
    logic [23:0] r_asm, n_asm;
    logic [1:0]  r_bip, n_bip;

    // Pixel job and palette read stage
    logic        r_job_vld, n_job_vld;
    t_job        r_job, n_job;
    logic        r_b_vld;
    t_pix        r_b;
    logic        r_b_pal;

    // Result slots
    t_pix               r_fifo [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_head, r_tail;
    logic [CNT_W-1:0]   r_cnt;

    logic [1:0]          cfg_idx;
    logic                cfg_wr, cfg_hit;
    logic [12:0]         eff_w, eff_h, rst_h, w_m1_full, h_m1_full, rst_m1_full;
    logic [11:0]         w_m1;
    t_depth              depth;
    logic [12:0]         w_p7, w_p1, avail;
    logic [14:0]         bpr, bpr_p3, bpr4, rbc_inc;
    logic [3:0]          ppb, pal_n, job_n;
    logic [COLOUR_W-1:0] job_col;
    logic                acc, pal_wr, byte_acc, in_row, col_in;
    logic [7:0]          in_idx, in_byte;
    logic [COLOUR_W-1:0] in_val;
    logic [CNT_W-1:0]    occ;
    logic                issue, job_done, use_pal, push, pop;
    logic [PAL_AW-1:0]   rd_idx;
    logic [COLOUR_W-1:0] ram_rd;
    t_pix                pix_in, pix_out;

    // ---------------------------------------------------------------
    // Register port
    // ---------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_hit = cfg_wr && (cfg_idx == REG_DEPTH || cfg_idx == REG_WIDTH
                                || cfg_idx == REG_HEIGHT);

    always_comb begin
        unique case (cfg_idx)
            REG_DEPTH:  prdata = {29'd0, r_depth};
            REG_WIDTH:  prdata = {19'd0, r_width};
            REG_HEIGHT: prdata = {19'd0, r_height};
            default:    prdata = 32'd0;
        endcase
    end

    // ---------------------------------------------------------------
    // Row geometry
    // ---------------------------------------------------------------
    assign eff_w       = eff_dim(r_width);
    assign eff_h       = eff_dim(r_height);
    assign depth       = eff_depth(r_depth);
    assign w_m1_full   = eff_w - 13'd1;
    assign w_m1        = w_m1_full[11:0];
    assign h_m1_full   = eff_h - 13'd1;
    assign rst_h       = (cfg_idx == REG_HEIGHT) ? eff_dim(pwdata[12:0]) : eff_h;
    assign rst_m1_full = rst_h - 13'd1;
    assign w_p7        = eff_w + 13'd7;
    assign w_p1        = eff_w + 13'd1;

    // Bytes of pixel data per row, then rounded up to whole words
    always_comb begin
        unique case (depth)
            DM_1BPP:  bpr = {5'd0, w_p7[12:3]};
            DM_4BPP:  bpr = {3'd0, w_p1[12:1]};
            DM_8BPP:  bpr = {2'd0, eff_w};
            DM_24BPP: bpr = {2'd0, eff_w} + {1'b0, eff_w, 1'b0};
            default:  bpr = {eff_w, 2'b00};
        endcase
    end
    assign bpr_p3 = bpr + 15'd3;
    assign bpr4   = {bpr_p3[14:2], 2'b00};

    // ---------------------------------------------------------------
    // Input side
    // ---------------------------------------------------------------
    assign in_idx  = s_axis_tdata[7:0];
    assign in_val  = s_axis_tdata[39:8];
    assign in_byte = s_axis_tdata[47:40];

    assign occ      = r_cnt + {{(CNT_W-1){1'b0}}, r_b_vld};
    assign issue    = r_job_vld && (occ < CNT_W'(FIFO_DEPTH));
    assign job_done = issue && (r_job.rem == 4'd1);

    // Take the next transfer when no job is pending or once the current byte's last pixel issues
    assign s_axis_tready = !r_job_vld || job_done;
    assign acc           = s_axis_tvalid && s_axis_tready;
    assign pal_wr        = acc && (s_axis_tuser == KIND_PALETTE);
    assign byte_acc      = acc && (s_axis_tuser == KIND_PIXEL);

    assign in_row  = r_rbc < bpr;
    assign col_in  = r_col < eff_w;
    assign avail   = eff_w - r_col;

    always_comb begin
        unique case (depth)
            DM_1BPP: ppb = 4'd8;
            DM_4BPP: ppb = 4'd2;
            default: ppb = 4'd1;
        endcase
    end

    // Pixels of this byte that still fall inside the row
    always_comb begin
        if (!col_in) begin
            pal_n = 4'd0;
        end else if (avail < {9'd0, ppb}) begin
            pal_n = avail[3:0];
        end else begin
            pal_n = ppb;
        end
    end

    assign rbc_inc = r_rbc + 15'd1;

    always_comb begin
        n_row   = r_row;
        n_col   = r_col;
        n_rbc   = r_rbc;
        n_asm   = r_asm;
        n_bip   = r_bip;
        job_n   = 4'd0;
        job_col = '0;
        if (byte_acc) begin
            if (in_row) begin
                unique case (depth)
                    DM_1BPP, DM_4BPP, DM_8BPP: begin
                        job_n = pal_n;
                    end
                    DM_24BPP: begin
                        if (r_bip >= 2'd2) begin
                            job_n   = {3'd0, col_in};
                            job_col = {8'h00, in_byte, r_asm[15:0]};
                            n_asm   = '0;
                            n_bip   = '0;
                        end else begin
                            n_bip = r_bip + 2'd1;
                            if (r_bip == 2'd0) begin
                                n_asm[7:0] = in_byte;
                            end else begin
                                n_asm[15:8] = in_byte;
                            end
                        end
                    end
                    default: begin
                        if (r_bip == 2'd3) begin
                            job_n   = {3'd0, col_in};
                            job_col = {in_byte, r_asm};
                            n_asm   = '0;
                            n_bip   = '0;
                        end else begin
                            n_bip = r_bip + 2'd1;
                            unique case (r_bip)
                                2'd0:    n_asm[7:0]   = in_byte;
                                2'd1:    n_asm[15:8]  = in_byte;
                                default: n_asm[23:16] = in_byte;
                            endcase
                        end
                    end
                endcase
                n_col = r_col + {9'd0, job_n};
            end
            // End of row including padding: advance one row up
            if (rbc_inc >= bpr4) begin
                n_rbc = '0;
                n_col = '0;
                n_asm = '0;
                n_bip = '0;
                n_row = (r_row == 12'd0) ? h_m1_full[11:0] : r_row - 12'd1;
            end else begin
                n_rbc = rbc_inc;
            end
        end
        // Register write restarts the frame
        if (cfg_hit) begin
            n_row = rst_m1_full[11:0];
            n_col = '0;
            n_rbc = '0;
            n_asm = '0;
            n_bip = '0;
        end
    end

    // ---------------------------------------------------------------
    // Pixel job: while result slots have room, one palette read or direct colour per cycle
    // ---------------------------------------------------------------
    always_comb begin
        unique case (r_job.depth)
            DM_1BPP: rd_idx = {7'd0, r_job.sh[7]};
            DM_4BPP: rd_idx = {4'd0, r_job.sh[7:4]};
            default: rd_idx = r_job.sh;
        endcase
        use_pal = (r_job.depth == DM_1BPP) || (r_job.depth == DM_4BPP)
                  || (r_job.depth == DM_8BPP);
    end

    always_comb begin
        n_job_vld = r_job_vld;
        n_job     = r_job;
        if (issue) begin
            n_job.rem = r_job.rem - 4'd1;
            n_job.x   = r_job.x + 12'd1;
            unique case (r_job.depth)
                DM_1BPP: n_job.sh = {r_job.sh[6:0], 1'b0};
                DM_4BPP: n_job.sh = {r_job.sh[3:0], 4'd0};
                default: n_job.sh = r_job.sh;
            endcase
            if (job_done) begin
                n_job_vld = 1'b0;
            end
        end
        if (byte_acc && job_n != 4'd0) begin
            n_job_vld    = 1'b1;
            n_job.x      = r_col[11:0];
            n_job.y      = r_row;
            n_job.rem    = job_n;
            n_job.sh     = in_byte;
            n_job.colour = job_col;
            n_job.depth  = depth;
            n_job.row0   = (r_row == 12'd0);
        end
    end

    bpu_ram #(
        .WIDTH (COLOUR_W),
        .DEPTH (PAL_DEPTH)
    ) u_palette (
        .i_clk   (i_clk),
        .i_we    (pal_wr),
        .i_waddr (in_idx),
        .i_wdata (in_val),
        .i_raddr (rd_idx),
        .o_rdata (ram_rd)
    );

    // ---------------------------------------------------------------
    // Result slots
    // ---------------------------------------------------------------
    assign push = r_b_vld;
    assign pop  = m_axis_tvalid && m_axis_tready;

    always_comb begin
        pix_in        = r_b;
        pix_in.colour = r_b_pal ? ram_rd : r_b.colour;
    end

    assign pix_out       = r_fifo[r_head];
    assign m_axis_tvalid = (r_cnt != '0);
    assign m_axis_tdata  = {pix_out.colour, pix_out.y, pix_out.x};
    assign m_axis_tlast  = pix_out.frame_last;
    assign m_axis_tuser  = pix_out.run_last;

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth   <= 3'd4;
            r_width   <= 13'd1;
            r_height  <= 13'd1;
            r_row     <= '0;
            r_col     <= '0;
            r_rbc     <= '0;
            r_asm     <= '0;
            r_bip     <= '0;
            r_job_vld <= 1'b0;
            r_b_vld   <= 1'b0;
            r_head    <= '0;
            r_tail    <= '0;
            r_cnt     <= '0;
        end else begin
            if (cfg_wr) begin
                unique case (cfg_idx)
                    REG_DEPTH:  r_depth  <= pwdata[2:0];
                    REG_WIDTH:  r_width  <= pwdata[12:0];
                    REG_HEIGHT: r_height <= pwdata[12:0];
                    default:    ;
                endcase
            end
            r_row     <= n_row;
            r_col     <= n_col;
            r_rbc     <= n_rbc;
            r_asm     <= n_asm;
            r_bip     <= n_bip;
            r_job_vld <= n_job_vld;
            r_b_vld   <= issue;
            if (push) begin
                r_tail <= r_tail + FIFO_AW'(1);
            end
            if (pop) begin
                r_head <= r_head + FIFO_AW'(1);
            end
            r_cnt <= r_cnt + {{(CNT_W-1){1'b0}}, push} - {{(CNT_W-1){1'b0}}, pop};
        end
    end

    // Payload: no reset
    always_ff @(posedge i_clk) begin
        r_job <= n_job;
        if (issue) begin
            r_b.x          <= r_job.x;
            r_b.y          <= r_job.y;
            r_b.colour     <= r_job.colour;
            r_b.run_last   <= (r_job.rem == 4'd1);
            r_b.frame_last <= r_job.row0 && (r_job.x == w_m1);
            r_b_pal        <= use_pal;
        end
        if (push) begin
            r_fifo[r_tail] <= pix_in;
        end
    end

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(FIFO_DEPTH))
        else $error("result slot count out of range");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_vld && r_cnt == CNT_W'(FIFO_DEPTH)) |-> pop)
        else $error("palette read lands in full result slots");

    a_job_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_job_vld |-> (r_job.rem != 4'd0))
        else $error("pending job with no pixels left");

    a_frame_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> m_axis_tuser)
        else $error("final pixel of image not last of its byte");

    a_issue_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        issue |=> (r_b_vld && $past(r_job.x) == r_b.x))
        else $error("issued pixel lost in read stage");

endmodule
